// ----- rtl/core/cuckoo_filter_engine_defines.svh -----
// Assertion macros used by the back end of the cuckoo filter engine RTL.
`ifndef CUCKOO_FILTER_ENGINE_DEFINES_SVH
`define CUCKOO_FILTER_ENGINE_DEFINES_SVH
`ifndef SYNTH
`define CFE_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("cfe assertion failed");
`define CFE_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cfe assertion failed");
`define CFE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cfe assertion failed");
`else
`define CFE_ASSERT_NEVER(lbl, expr)
`define CFE_ASSERT_IMPLY(lbl, ante, cons)
`define CFE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/core/cfe_pkg.sv -----
// Constants, types and helpers of the cuckoo filter engine.
package cfe_pkg;
  localparam int BUCKETS    = 1024;
  localparam int SLOTS      = 4;
  localparam int FP_BITS    = 16;
  localparam int KICK_DEPTH = 512;

  localparam int BUCKET_W = $clog2(BUCKETS);
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int ROW_W    = SLOTS * FP_BITS;
  localparam int UNDO_AW  = $clog2(KICK_DEPTH);
  localparam int UNDO_W   = BUCKET_W + SLOT_W + FP_BITS;
  localparam int KCNT_W   = $clog2(KICK_DEPTH + 1);
  localparam int CFG_W    = 10;
  localparam int CNT_W    = 13;
  localparam int HASH_W   = 64;

  localparam logic [CFG_W-1:0] KICK_RESET = CFG_W'(500);

  localparam logic [63:0] GOLDEN   = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_C1   = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_C2   = 64'h94d049bb133111eb;
  localparam logic [63:0] RNG_SEED = 64'hD1B54A32D192ED03;

  localparam int TABLE_ENTRIES = BUCKETS * SLOTS;
  localparam int FILL_CAP      = (TABLE_ENTRIES / 100) * 95 + ((TABLE_ENTRIES % 100) * 95) / 100;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  localparam logic [1:0] FAIL_NONE = 2'd0;
  localparam logic [1:0] FAIL_LOAD = 2'd1;
  localparam logic [1:0] FAIL_KICK = 2'd2;

  typedef struct packed {
    logic                kind;
    logic [FP_BITS-1:0]  fp;
    logic [BUCKET_W-1:0] b1;
  } item_t;

  typedef struct packed {
    logic [BUCKET_W-1:0] bucket;
    logic [SLOT_W-1:0]   slot;
    logic [FP_BITS-1:0]  old_fp;
  } undo_t;

  // Elaboration-time mixer, used only for the generator's reset value.
  function automatic logic [63:0] mix64_c(input logic [63:0] v_in);
    logic [63:0] v;
    v = v_in + GOLDEN;
    v = (v ^ (v >> 30)) * MIX_C1;
    v = (v ^ (v >> 27)) * MIX_C2;
    return v ^ (v >> 31);
  endfunction

  localparam logic [63:0] RNG_INIT = mix64_c(64'(BUCKETS) ^ RNG_SEED);
endpackage

// ----- rtl/core/cfe_ram.sv -----
// Generic single-port RAM with registered read.
module cfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ----- rtl/core/cfe_mix.sv -----
// Multi-cycle splitmix64 finalizer on one shared 32x32 multiplier.
module cfe_mix (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] din,
  output logic        done,
  output logic [63:0] dout
);
  import cfe_pkg::*;

  logic        busy;
  logic [2:0]  ph;
  logic [63:0] x;
  logic [63:0] acc;
  logic [63:0] pre;
  logic [63:0] kc;
  logic [1:0]  part;
  logic [31:0] ma;
  logic [31:0] mb;
  logic [63:0] prod;

  assign pre  = din + GOLDEN;
  assign kc   = ph[2] ? MIX_C2 : MIX_C1;
  assign part = ph[1:0];
  assign ma   = (part == 2'd2) ? x[63:32] : x[31:0];
  assign mb   = (part == 2'd1) ? kc[63:32] : kc[31:0];
  assign prod = ma * mb;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      ph   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x    <= pre ^ (pre >> 30);
        ph   <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        ph <= ph + 3'd1;
        case (ph)
          3'd3: begin
            x <= acc ^ (acc >> 27);
          end
          3'd7: begin
            dout <= acc ^ (acc >> 31);
            done <= 1'b1;
            busy <= 1'b0;
          end
          default: begin
            if (part == 2'd0) begin
              acc <= prod;
            end else begin
              acc <= acc + {prod[31:0], 32'b0};
            end
          end
        endcase
      end
    end
  end
endmodule

// ----- rtl/core/cfe_front.sv -----
// Front end: takes words, derives fingerprint and primary bucket, queues them.
module cfe_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic                        kind,
  input  logic [cfe_pkg::HASH_W-1:0]  item_hash,
  output logic                        q_valid,
  output cfe_pkg::item_t              q_item,
  input  logic                        q_pop
);
  import cfe_pkg::*;

  item_t              slots_q [2];
  logic               wr_ptr;
  logic               rd_ptr;
  logic [1:0]         fill;
  logic [FP_BITS-1:0] top;
  item_t              cls;
  logic               do_push;
  logic               do_pop;

  assign top     = item_hash[HASH_W-1 -: FP_BITS];
  assign cls.kind = kind;
  assign cls.fp   = (top == {FP_BITS{1'b1}}) ? FP_BITS'(1) : top + FP_BITS'(1);
  assign cls.b1   = item_hash[BUCKET_W-1:0];

  assign full    = (fill == 2'd2);
  assign q_valid = (fill != 2'd0);
  assign q_item  = slots_q[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        slots_q[wr_ptr] <= cls;
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= fill + 2'(do_push) - 2'(do_pop);
    end
  end
endmodule

// ----- rtl/core/cfe_back.sv -----
// Back end: table clear, lookup, insert, eviction walk and rollback.
module cfe_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  cfe_pkg::item_t              q_item,
  output logic                        q_pop,
  input  logic                        cfg_we,
  input  logic [cfe_pkg::CFG_W-1:0]   cfg_wdata,
  output logic                        res_valid,
  input  logic                        res_pop,
  output logic                        res_ok,
  output logic [1:0]                  res_fail,
  output logic [cfe_pkg::CNT_W-1:0]   res_occ
);
  import cfe_pkg::*;
  `include "cuckoo_filter_engine_defines.svh"

  typedef enum logic [14:0] {
    S_CLEAR  = 15'b000000000000001,
    S_IDLE   = 15'b000000000000010,
    S_MIXA   = 15'b000000000000100,
    S_RD2    = 15'b000000000001000,
    S_DECIDE = 15'b000000000010000,
    S_RNDV   = 15'b000000000100000,
    S_KSTART = 15'b000000001000000,
    S_KMIX   = 15'b000000010000000,
    S_KSWAP  = 15'b000000100000000,
    S_KALT   = 15'b000001000000000,
    S_KRD    = 15'b000010000000000,
    S_KCHK   = 15'b000100000000000,
    S_RBRD   = 15'b001000000000000,
    S_RBUR   = 15'b010000000000000,
    S_RBWR   = 15'b100000000000000
  } state_t;

  state_t              state;
  logic [BUCKET_W-1:0] clr_cnt;
  logic                kind;
  logic [FP_BITS-1:0]  fp;
  logic [BUCKET_W-1:0] b1;
  logic [BUCKET_W-1:0] b2;
  logic [BUCKET_W-1:0] vb;
  logic [ROW_W-1:0]    row1;
  logic [ROW_W-1:0]    row2;
  logic [ROW_W-1:0]    vrow;
  logic [SLOT_W-1:0]   s;
  logic [KCNT_W-1:0]   k;
  logic [KCNT_W-1:0]   lim;
  logic [63:0]         rnd;
  logic [63:0]         saved;
  undo_t               ent;
  logic [CNT_W-1:0]    count;
  logic [CFG_W-1:0]    kick_limit;

  logic                tab_we;
  logic [BUCKET_W-1:0] tab_addr;
  logic [ROW_W-1:0]    tab_wdata;
  logic [ROW_W-1:0]    rd;
  logic                undo_we;
  logic [UNDO_AW-1:0]  undo_addr;
  undo_t               undo_wdata;
  logic [UNDO_W-1:0]   undo_rraw;
  undo_t               undo_rdata;
  logic                mix_start;
  logic [63:0]         mix_din;
  logic                mix_done;
  logic [63:0]         mix_dout;

  logic                match;
  logic                e1;
  logic                e2;
  logic [SLOT_W-1:0]   e1_idx;
  logic [SLOT_W-1:0]   e2_idx;
  logic [FP_BITS-1:0]  old_fp;
  logic [BUCKET_W-1:0] delta;
  logic [BUCKET_W-1:0] alt_next;
  logic                can_place;

  function automatic logic has_fp(input logic [ROW_W-1:0] row, input logic [FP_BITS-1:0] f);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      hit = hit | (row[i*FP_BITS +: FP_BITS] == f);
    end
    return hit;
  endfunction

  function automatic logic [SLOT_W:0] first_zero(input logic [ROW_W-1:0] row);
    logic [SLOT_W:0] r;
    r = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (row[i*FP_BITS +: FP_BITS] == '0) begin
        r = {1'b1, SLOT_W'(i)};
      end
    end
    return r;
  endfunction

  function automatic logic [ROW_W-1:0] put(input logic [ROW_W-1:0] row,
                                           input logic [SLOT_W-1:0] idx,
                                           input logic [FP_BITS-1:0] f);
    logic [ROW_W-1:0] r;
    r = row;
    r[idx*FP_BITS +: FP_BITS] = f;
    return r;
  endfunction

  cfe_ram #(.WIDTH(ROW_W), .DEPTH(BUCKETS)) u_table (
    .clk(clk), .we(tab_we), .addr(tab_addr), .wdata(tab_wdata), .rdata(rd)
  );

  cfe_ram #(.WIDTH(UNDO_W), .DEPTH(KICK_DEPTH)) u_undo (
    .clk(clk), .we(undo_we), .addr(undo_addr), .wdata(undo_wdata), .rdata(undo_rraw)
  );

  cfe_mix u_mix (
    .clk(clk), .rst(rst), .start(mix_start), .din(mix_din), .done(mix_done), .dout(mix_dout)
  );

  assign undo_rdata = undo_t'(undo_rraw);
  assign match      = has_fp(row1, fp) || has_fp(rd, fp);
  assign {e1, e1_idx} = first_zero(row1);
  assign {e2, e2_idx} = first_zero(rd);
  assign old_fp     = vrow[s*FP_BITS +: FP_BITS];
  assign delta      = (mix_dout[BUCKET_W-1:0] == '0) ? BUCKET_W'(1) : mix_dout[BUCKET_W-1:0];
  assign alt_next   = ((state == S_MIXA) ? b1 : vb) ^ delta;
  assign lim        = (kick_limit > CFG_W'(KICK_DEPTH)) ? KCNT_W'(KICK_DEPTH)
                                                        : KCNT_W'(kick_limit);
  assign can_place  = (kind == KIND_INSERT) && !match && (count < CNT_W'(FILL_CAP));
  assign res_occ    = count;

  always_comb begin
    tab_we     = 1'b0;
    tab_addr   = b2;
    tab_wdata  = rd;
    undo_we    = 1'b0;
    undo_addr  = k[UNDO_AW-1:0];
    undo_wdata = '{bucket: vb, slot: s, old_fp: old_fp};
    mix_start  = 1'b0;
    mix_din    = rnd + GOLDEN;
    q_pop      = 1'b0;
    unique case (state) inside
      S_CLEAR: begin
        tab_we    = 1'b1;
        tab_addr  = clr_cnt;
        tab_wdata = '0;
      end
      S_IDLE: begin
        tab_addr = q_item.b1;
        if (q_valid && !res_valid) begin
          q_pop     = 1'b1;
          mix_start = 1'b1;
          mix_din   = 64'(q_item.fp);
        end
      end
      S_MIXA: tab_addr = b1;
      S_RD2: tab_addr = b2;
      S_DECIDE: begin
        if (can_place) begin
          if (e1) begin
            tab_we    = 1'b1;
            tab_addr  = b1;
            tab_wdata = put(row1, e1_idx, fp);
          end else if (e2) begin
            tab_we    = 1'b1;
            tab_wdata = put(rd, e2_idx, fp);
          end else begin
            mix_start = 1'b1;
          end
        end
      end
      S_RNDV, S_KMIX, S_KALT: begin
      end
      S_KSTART: mix_start = (k != lim);
      S_KSWAP: begin
        tab_we    = 1'b1;
        tab_addr  = vb;
        tab_wdata = put(vrow, s, fp);
        undo_we   = 1'b1;
        mix_start = 1'b1;
        mix_din   = 64'(old_fp);
      end
      S_KRD: tab_addr = vb;
      S_KCHK: begin
        tab_addr = vb;
        if (e2) begin
          tab_we    = 1'b1;
          tab_wdata = put(rd, e2_idx, fp);
        end
      end
      S_RBRD: undo_addr = UNDO_AW'(k - KCNT_W'(1));
      S_RBUR: tab_addr = undo_rdata.bucket;
      S_RBWR: begin
        tab_we    = 1'b1;
        tab_addr  = ent.bucket;
        tab_wdata = put(rd, ent.slot, ent.old_fp);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_cnt    <= '0;
      count      <= '0;
      rnd        <= RNG_INIT;
      kick_limit <= KICK_RESET;
      res_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        kick_limit <= cfg_wdata;
      end
      if (res_valid && res_pop) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + BUCKET_W'(1);
          if (clr_cnt == BUCKET_W'(BUCKETS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid && !res_valid) begin
            kind  <= q_item.kind;
            fp    <= q_item.fp;
            b1    <= q_item.b1;
            state <= S_MIXA;
          end
        end
        S_MIXA: begin
          if (mix_done) begin
            b2    <= alt_next;
            row1  <= rd;
            state <= S_RD2;
          end
        end
        S_RD2: state <= S_DECIDE;
        S_DECIDE: begin
          row2 <= rd;
          if (can_place && !e1 && !e2) begin
            saved <= rnd;
            rnd   <= rnd + GOLDEN;
            state <= S_RNDV;
          end else begin
            res_valid <= 1'b1;
            res_ok    <= match || can_place;
            res_fail  <= (kind == KIND_INSERT && !match && !can_place) ? FAIL_LOAD : FAIL_NONE;
            if (can_place) begin
              count <= count + CNT_W'(1);
            end
            state <= S_IDLE;
          end
        end
        S_RNDV: begin
          if (mix_done) begin
            vb    <= mix_dout[0] ? b2 : b1;
            vrow  <= mix_dout[0] ? row2 : row1;
            k     <= '0;
            state <= S_KSTART;
          end
        end
        S_KSTART: begin
          if (k == lim) begin
            state <= S_RBRD;
          end else begin
            rnd   <= rnd + GOLDEN;
            state <= S_KMIX;
          end
        end
        S_KMIX: begin
          if (mix_done) begin
            s     <= mix_dout[SLOT_W-1:0];
            state <= S_KSWAP;
          end
        end
        S_KSWAP: begin
          fp    <= old_fp;
          state <= S_KALT;
        end
        S_KALT: begin
          if (mix_done) begin
            vb    <= alt_next;
            state <= S_KRD;
          end
        end
        S_KRD: state <= S_KCHK;
        S_KCHK: begin
          if (e2) begin
            count     <= count + CNT_W'(1);
            res_valid <= 1'b1;
            res_ok    <= 1'b1;
            res_fail  <= FAIL_NONE;
            state     <= S_IDLE;
          end else begin
            vrow  <= rd;
            k     <= k + KCNT_W'(1);
            state <= S_KSTART;
          end
        end
        S_RBRD: begin
          if (k == '0) begin
            rnd       <= saved;
            res_valid <= 1'b1;
            res_ok    <= 1'b0;
            res_fail  <= FAIL_KICK;
            state     <= S_IDLE;
          end else begin
            k     <= k - KCNT_W'(1);
            state <= S_RBUR;
          end
        end
        S_RBUR: begin
          ent   <= undo_rdata;
          state <= S_RBWR;
        end
        S_RBWR: state <= S_RBRD;
        default: state <= S_IDLE;
      endcase
    end
  end

  `CFE_ASSERT_NEVER(a_count_limit, count > CNT_W'(FILL_CAP))
  `CFE_ASSERT_NEXT(a_result_held, res_valid && !res_pop, res_valid)
  `CFE_ASSERT_IMPLY(a_fail_not_ok, res_valid && res_fail != FAIL_NONE, !res_ok)
  `CFE_ASSERT_NEVER(a_kick_bound, state == S_KSTART && k > lim)
endmodule

// ----- rtl/core/cuckoo_filter_engine.sv -----
// Top level of the cuckoo filter engine.
// After reset the table is cleared; words are queued meanwhile.
// A lookup, a duplicate, a load-limit reject or a direct insert is paced by the
// shared splitmix64 mixer (one 32x32 multiplier) and the single-port bucket RAM.
// An insert that evicts walks evictions, each of two mixer passes, the swap and
// a bucket read; on failure each eviction is undone in turn. A 2-word input
// queue and a result register decouple both sides; results come out in input
// order.
module cuckoo_filter_engine (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic                        kind,
  input  logic [cfe_pkg::HASH_W-1:0]  item_hash,
  output logic                        empty,
  input  logic                        pop,
  output logic                        ok,
  output logic [1:0]                  failure,
  output logic [cfe_pkg::CNT_W-1:0]   occupancy,
  input  logic                        cfg_we,
  input  logic [cfe_pkg::CFG_W-1:0]   cfg_wdata
);
  import cfe_pkg::*;

  logic  q_valid;
  item_t q_item;
  logic  q_pop;
  logic  res_valid;

  cfe_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .kind(kind), .item_hash(item_hash),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  cfe_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .res_valid(res_valid), .res_pop(pop), .res_ok(ok), .res_fail(failure),
    .res_occ(occupancy)
  );

  assign empty = !res_valid;
endmodule
